// File: design/bicubic_resize_plane_macros.svh
`ifndef BICUBIC_RESIZE_PLANE_MACROS_SVH
`define BICUBIC_RESIZE_PLANE_MACROS_SVH

// same-cycle implication
`define BCR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bicubic resize assertion failed");

// next-cycle implication
`define BCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bicubic resize assertion failed");

`endif

// File: design/bcr_pkg.sv
`default_nettype none
package bcr_pkg;

   localparam int MAX_SRC_W_DEF   = 256;
   localparam int MAX_SRC_H_DEF   = 256;
   localparam int MAX_DST_DIM_DEF = 1024;

   localparam int SRC_DIM_W  = 9;
   localparam int DST_DIM_W  = 11;
   localparam int COORD_W    = 10;
   localparam int PIX_W      = 8;
   localparam int WGT_W      = 16;
   localparam int AX_NUM_W   = 51;
   localparam int AX_DEN_W   = 51;
   localparam int FIN_NUM_W  = 44;
   localparam int FIN_DEN_W  = 36;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH  = 3'd0,
      CSR_SOURCE_HEIGHT = 3'd1,
      CSR_TARGET_WIDTH  = 3'd2,
      CSR_TARGET_HEIGHT = 3'd3,
      CSR_ANTIALIAS     = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_COMPUTE = 1'b1
   } op_type;

endpackage
`default_nettype wire

// File: design/bcr_ram.sv
`default_nettype none
module bcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

// File: design/bcr_div.sv
`default_nettype none
module bcr_div #(
   parameter int NUM_W = 51,
   parameter int DEN_W = 51
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic      [NUM_W-1:0] quo
);

   localparam int CW = $clog2(NUM_W);

   logic [NUM_W-1:0] n_ff;
   logic [DEN_W-1:0] d_ff;
   logic [DEN_W-1:0] r_ff;
   logic [DEN_W-1:0] r_in;
   logic [DEN_W:0]   trial;
   logic             ge;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   always_comb begin
      trial = {r_ff, n_ff[NUM_W-1]};
      ge    = trial >= {1'b0, d_ff};
      r_in  = ge ? DEN_W'(trial - {1'b0, d_ff}) : DEN_W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            n_ff    <= num;
            d_ff    <= den;
            r_ff    <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            n_ff   <= {n_ff[NUM_W-2:0], ge};
            r_ff   <= r_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = n_ff;

endmodule
`default_nettype wire

// File: design/bcr_axis.sv
`default_nettype none
module bcr_axis #(
   parameter int IDX_W = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [bcr_pkg::SRC_DIM_W-1:0]       src,
   input  wire logic [bcr_pkg::DST_DIM_W-1:0]       dst,
   input  wire logic [bcr_pkg::COORD_W-1:0]         d,
   input  wire logic                                aa_en,
   output logic                                     done,
   output logic      [3:0][IDX_W-1:0]               idx,
   output logic      [3:0][bcr_pkg::WGT_W-1:0]      w
);

   localparam int NW = bcr_pkg::AX_NUM_W;
   localparam int DW = bcr_pkg::AX_DEN_W;

   typedef enum logic [4:0] {
      A_IDLE, A_SCL, A_MAP, A_MAP2, A_SSQ, A_K, A_KDIV, A_SQ, A_CU, A_CU2,
      A_POLY, A_GA, A_GB, A_GU, A_TM, A_TD, A_TW, A_E1, A_E2, A_E3, A_E4,
      A_W, A_W2, A_NEXT
   } state_type;

   function automatic logic signed [23:0] sdiv4(input logic signed [23:0] p);
      logic signed [23:0] t;
      t = p[23] ? p + 24'sd3 : p;
      return t >>> 2;
   endfunction

   function automatic logic [21:0] clamp_idx(input logic signed [21:0] v,
                                             input logic [8:0] n);
      logic signed [21:0] ns;
      ns = $signed({13'b0, n});
      if (v < 22'sd0) return 22'd0;
      if (v >= ns) return 22'(ns - 22'sd1);
      return 22'(v);
   endfunction

   state_type          state_ff;
   logic [8:0]         src_ff;
   logic [9:0]         d_ff;
   logic               aa_en_ff;
   logic [24:0]        scale_ff;
   logic               aa_ff;
   logic [15:0]        frac_ff;
   logic [49:0]        ssq_ff;
   logic [1:0]         k_ff;
   logic [17:0]        x_ff;
   logic [17:0]        x2_ff;
   logic signed [23:0] c_ff;
   logic [14:0]        v_ff;
   logic [16:0]        term_ff;
   logic signed [17:0] sum_ff;
   logic [2:0]         t_ff;
   logic [16:0]        e1_ff;
   logic [16:0]        g_ff;
   logic               done_ff;
   logic [3:0][IDX_W-1:0]          idx_ff;
   logic [3:0][bcr_pkg::WGT_W-1:0] w_ff;
   logic signed [51:0] mul_ff;

   logic signed [25:0] mul_a;
   logic signed [25:0] mul_b;
   logic               div_start;
   logic [NW-1:0]      div_num;
   logic [DW-1:0]      div_den;
   logic               div_done;
   logic [NW-1:0]      div_quo;
   logic [17:0]        mag;
   logic [35:0]        r_w;
   logic signed [21:0] ip_w;
   logic [3:0][21:0]   cl_w;
   logic [18:0]        x3_w;
   logic signed [23:0] p1_w;
   logic signed [23:0] p2_w;
   logic signed [23:0] c_in;
   logic signed [23:0] w_plain;
   logic signed [51:0] wadj;

   bcr_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_comb begin
      case (k_ff)
         2'd0:    mag = {2'b0, frac_ff} + 18'd65536;
         2'd1:    mag = {2'b0, frac_ff};
         2'd2:    mag = 18'd65536 - {2'b0, frac_ff};
         default: mag = 18'd131072 - {2'b0, frac_ff};
      endcase
   end

   always_comb begin
      r_w  = {1'b0, mul_ff[35:1]} + 36'd229376;
      ip_w = $signed({2'b0, r_w[35:16]}) - 22'sd4;
      for (int k = 0; k < 4; k++) begin
         cl_w[k] = clamp_idx(ip_w + $signed(22'(k)) - 22'sd1, src_ff);
      end
   end

   always_comb begin
      x3_w = mul_ff[34:16];
      p1_w = 24'sd5 * $signed({5'b0, x3_w}) - 24'sd9 * $signed({6'b0, x2_ff})
           + 24'sd262144;
      p2_w = 24'sd15 * $signed({6'b0, x2_ff}) - 24'sd3 * $signed({5'b0, x3_w})
           - 24'sd24 * $signed({6'b0, x_ff}) + 24'sd786432;
      if (x_ff[17]) begin
         c_in = 24'sd0;
      end else if (x_ff <= 18'd65536) begin
         c_in = sdiv4(p1_w);
      end else begin
         c_in = sdiv4(p2_w);
      end
      w_plain = sdiv4(c_in);
      wadj    = mul_ff[51] ? mul_ff + 52'sd262143 : mul_ff;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         A_MAP: begin
            mul_a = $signed({1'b0, scale_ff});
            mul_b = $signed({15'b0, d_ff, 1'b1});
         end
         A_MAP2: begin
            mul_a = $signed({1'b0, scale_ff});
            mul_b = $signed({1'b0, scale_ff});
         end
         A_SQ: begin
            mul_a = $signed({8'b0, x_ff});
            mul_b = $signed({8'b0, x_ff});
         end
         A_CU2: begin
            mul_a = $signed({8'b0, x2_ff});
            mul_b = $signed({8'b0, x_ff});
         end
         A_GA: begin
            mul_a = $signed({8'b0, mag});
            mul_b = $signed({8'b0, mag});
         end
         A_TM: begin
            mul_a = $signed({9'b0, term_ff});
            mul_b = $signed({11'b0, v_ff});
         end
         A_E1: begin
            mul_a = {{8{sum_ff[17]}}, sum_ff};
            mul_b = {{8{sum_ff[17]}}, sum_ff};
         end
         A_E3: begin
            mul_a = $signed({9'b0, e1_ff});
            mul_b = $signed({9'b0, e1_ff});
         end
         A_W: begin
            mul_a = {{2{c_ff[23]}}, c_ff};
            mul_b = $signed({9'b0, g_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (state_ff)
         A_IDLE: begin
            div_start = start;
            div_num   = NW'({src, 16'b0});
            div_den   = DW'(dst);
         end
         A_K: begin
            div_start = aa_ff;
            div_num   = NW'({mag, 16'b0});
            div_den   = DW'(scale_ff);
         end
         A_GB: begin
            div_start = 1'b1;
            div_num   = {mul_ff[34:0], 16'b0};
            div_den   = DW'({ssq_ff, 1'b0});
         end
         A_TD: begin
            div_start = 1'b1;
            div_num   = NW'(mul_ff[31:0]);
            div_den   = DW'({t_ff, 16'b0});
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            A_IDLE: begin
               if (start) begin
                  src_ff   <= src;
                  d_ff     <= d;
                  aa_en_ff <= aa_en;
                  state_ff <= A_SCL;
               end
            end
            A_SCL: begin
               if (div_done) begin
                  scale_ff <= div_quo[24:0];
                  state_ff <= A_MAP;
               end
            end
            A_MAP: begin
               state_ff <= A_MAP2;
            end
            A_MAP2: begin
               frac_ff <= r_w[15:0];
               aa_ff   <= aa_en_ff && (scale_ff > 25'd65536);
               for (int k = 0; k < 4; k++) begin
                  idx_ff[k] <= cl_w[k][IDX_W-1:0];
               end
               state_ff <= A_SSQ;
            end
            A_SSQ: begin
               ssq_ff   <= mul_ff[49:0];
               k_ff     <= 2'd0;
               state_ff <= A_K;
            end
            A_K: begin
               if (aa_ff) begin
                  state_ff <= A_KDIV;
               end else begin
                  x_ff     <= mag;
                  state_ff <= A_SQ;
               end
            end
            A_KDIV: begin
               if (div_done) begin
                  x_ff     <= (|div_quo[NW-1:18]) ? 18'h20000 : div_quo[17:0];
                  state_ff <= A_SQ;
               end
            end
            A_SQ: begin
               state_ff <= A_CU;
            end
            A_CU: begin
               x2_ff    <= mul_ff[33:16];
               state_ff <= A_CU2;
            end
            A_CU2: begin
               state_ff <= A_POLY;
            end
            A_POLY: begin
               c_ff <= c_in;
               if (aa_ff) begin
                  state_ff <= A_GA;
               end else begin
                  w_ff[k_ff] <= w_plain[15:0];
                  state_ff   <= A_NEXT;
               end
            end
            A_GA: begin
               state_ff <= A_GB;
            end
            A_GB: begin
               state_ff <= A_GU;
            end
            A_GU: begin
               if (div_done) begin
                  v_ff     <= div_quo[16:2];
                  term_ff  <= 17'd65536;
                  sum_ff   <= 18'sd65536;
                  t_ff     <= 3'd1;
                  state_ff <= A_TM;
               end
            end
            A_TM: begin
               state_ff <= A_TD;
            end
            A_TD: begin
               state_ff <= A_TW;
            end
            A_TW: begin
               if (div_done) begin
                  term_ff <= div_quo[16:0];
                  if (t_ff[0]) begin
                     sum_ff <= sum_ff - $signed({1'b0, div_quo[16:0]});
                  end else begin
                     sum_ff <= sum_ff + $signed({1'b0, div_quo[16:0]});
                  end
                  t_ff     <= t_ff + 3'd1;
                  state_ff <= (t_ff == 3'd5) ? A_E1 : A_TM;
               end
            end
            A_E1: begin
               state_ff <= A_E2;
            end
            A_E2: begin
               e1_ff    <= mul_ff[32:16];
               state_ff <= A_E3;
            end
            A_E3: begin
               state_ff <= A_E4;
            end
            A_E4: begin
               g_ff     <= mul_ff[32:16];
               state_ff <= A_W;
            end
            A_W: begin
               state_ff <= A_W2;
            end
            A_W2: begin
               w_ff[k_ff] <= wadj[33:18];
               state_ff   <= A_NEXT;
            end
            A_NEXT: begin
               if (k_ff == 2'd3) begin
                  done_ff  <= 1'b1;
                  state_ff <= A_IDLE;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= A_K;
               end
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign done = done_ff;
   assign idx  = idx_ff;
   assign w    = w_ff;

endmodule
`default_nettype wire

// File: design/bicubic_resize_plane.sv
// channel   dir  handshake            tdata (low bit up)                    tuser
// req_      in   req_tvalid/tready    coord_x, coord_y, pixel_in            opcode
// rsp_      out  rsp_tvalid/tready    pixel_out, out_x, out_y               -
// csr_      in   csr_we               csr_index selects, csr_wdata value    -
//
// a compute's length is set by the serial dividers (one quotient bit per cycle) and
// the sixteen source reads, and it grows when antialias applies to one downscaled axis
// and grows further when it applies to both
// reset is synchronous and active high; the source memory is not cleared
// a finished result waits in the output register while loads are still taken
`default_nettype none
module bicubic_resize_plane #(
   parameter int MAX_SRC_W   = bcr_pkg::MAX_SRC_W_DEF,
   parameter int MAX_SRC_H   = bcr_pkg::MAX_SRC_H_DEF,
   parameter int MAX_DST_DIM = bcr_pkg::MAX_DST_DIM_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [31:0]                      req_tdata,  // coord_x, coord_y, pixel_in
   input  wire logic                             req_tuser,  // opcode
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [31:0]                      rsp_tdata,  // pixel_out, out_x, out_y
   input  wire logic                             csr_we,
   input  wire logic [bcr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bcr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

`include "bicubic_resize_plane_macros.svh"

   localparam int XI_W  = $clog2(MAX_SRC_W);
   localparam int YI_W  = $clog2(MAX_SRC_H);
   localparam int IDX_W = (XI_W > YI_W) ? XI_W : YI_W;
   localparam int DEPTH = MAX_SRC_W * MAX_SRC_H;
   localparam int AW    = $clog2(DEPTH);
   localparam int WG    = bcr_pkg::WGT_W;
   localparam int FNW   = bcr_pkg::FIN_NUM_W;
   localparam int FDW   = bcr_pkg::FIN_DEN_W;

   typedef enum logic [2:0] {
      S_IDLE, S_AXS, S_AXW, S_ACC, S_FIN, S_DIV, S_OUT
   } state_type;

   function automatic logic [12:0] limit_dim(input logic [12:0] v, input logic [12:0] mx);
      if (v == 13'd0) return 13'd1;
      return (v > mx) ? mx : v;
   endfunction

   state_type          state_ff;
   logic [8:0]         src_w_ff;
   logic [8:0]         src_h_ff;
   logic [10:0]        dst_w_ff;
   logic [10:0]        dst_h_ff;
   logic               aa_ff;
   logic [9:0]         cx_ff;
   logic [9:0]         cy_ff;
   logic               ax_sel_ff;
   logic [3:0][XI_W-1:0] xi_ff;
   logic [3:0][YI_W-1:0] yi_ff;
   logic [3:0][WG-1:0] wx_ff;
   logic [3:0][WG-1:0] wy_ff;
   logic [4:0]         acc_cnt_ff;
   logic               p1_ff;
   logic               p2_ff;
   logic signed [31:0] w0_ff;
   logic signed [31:0] w1_ff;
   logic signed [40:0] prod_ff;
   logic signed [41:0] sum_ff;
   logic signed [33:0] wsum_ff;
   logic [7:0]         q_ff;
   logic               rsp_tvalid_ff;
   logic [7:0]         pix_out_ff;
   logic [9:0]         out_x_ff;
   logic [9:0]         out_y_ff;

   logic [8:0]         sw;
   logic [8:0]         sh;
   logic [10:0]        tw;
   logic [10:0]        th;
   logic [12:0]        sw_l;
   logic [12:0]        sh_l;
   logic [12:0]        tw_l;
   logic [12:0]        th_l;
   logic               req_xfer;
   logic [9:0]         req_x;
   logic [9:0]         req_y;
   logic [7:0]         req_pix;
   logic               mem_we;
   logic [AW-1:0]      mem_waddr;
   logic               mem_re;
   logic [AW-1:0]      mem_raddr;
   logic [7:0]         mem_rdata;
   logic [1:0]         ai;
   logic [1:0]         aj;
   logic               ax_start;
   logic               ax_done;
   logic [3:0][IDX_W-1:0] ax_idx;
   logic [3:0][WG-1:0] ax_w;
   logic [41:0]        ms;
   logic [33:0]        mw;
   logic               fin_zero;
   logic               div_start;
   logic [FNW-1:0]     div_num;
   logic [FDW-1:0]     div_den;
   logic               div_done;
   logic [FNW-1:0]     div_quo;

   always_comb begin
      sw_l = limit_dim(13'(src_w_ff), 13'(MAX_SRC_W));
      sh_l = limit_dim(13'(src_h_ff), 13'(MAX_SRC_H));
      tw_l = limit_dim(13'(dst_w_ff), 13'(MAX_DST_DIM));
      th_l = limit_dim(13'(dst_h_ff), 13'(MAX_DST_DIM));
      sw   = sw_l[8:0];
      sh   = sh_l[8:0];
      tw   = tw_l[10:0];
      th   = th_l[10:0];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign req_x      = req_tdata[9:0];
   assign req_y      = req_tdata[19:10];
   assign req_pix    = req_tdata[27:20];

   assign mem_we    = req_xfer && (req_tuser == 1'(bcr_pkg::OP_LOAD))
                    && (32'(req_x) < 32'(MAX_SRC_W)) && (32'(req_y) < 32'(MAX_SRC_H));
   assign mem_waddr = AW'(32'(req_y) * MAX_SRC_W + 32'(req_x));

   assign ai        = acc_cnt_ff[3:2];
   assign aj        = acc_cnt_ff[1:0];
   assign mem_re    = (state_ff == S_ACC) && !acc_cnt_ff[4];
   assign mem_raddr = AW'(32'(yi_ff[ai]) * MAX_SRC_W + 32'(xi_ff[aj]));

   bcr_ram #(.WIDTH(bcr_pkg::PIX_W), .DEPTH(DEPTH)) u_src_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (req_pix),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign ax_start = (state_ff == S_AXS);

   bcr_axis #(.IDX_W(IDX_W)) u_axis (
      .clock (clock),
      .reset (reset),
      .start (ax_start),
      .src   (ax_sel_ff ? sh : sw),
      .dst   (ax_sel_ff ? th : tw),
      .d     (ax_sel_ff ? cy_ff : cx_ff),
      .aa_en (aa_ff),
      .done  (ax_done),
      .idx   (ax_idx),
      .w     (ax_w)
   );

   always_comb begin
      ms        = sum_ff[41] ? 42'(-sum_ff) : 42'(sum_ff);
      mw        = wsum_ff[33] ? 34'(-wsum_ff) : 34'(wsum_ff);
      fin_zero  = (wsum_ff == 34'sd0) || (sum_ff == 42'sd0) || (sum_ff[41] != wsum_ff[33]);
      div_start = (state_ff == S_FIN) && !fin_zero;
      div_num   = FNW'({ms, 1'b0}) + FNW'(mw);
      div_den   = FDW'({mw, 1'b0});
   end

   bcr_div #(.NUM_W(FNW), .DEN_W(FDW)) u_fin_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 9'd256;
         src_h_ff <= 9'd256;
         dst_w_ff <= 11'd256;
         dst_h_ff <= 11'd256;
         aa_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            bcr_pkg::CSR_SOURCE_WIDTH:  src_w_ff <= csr_wdata[8:0];
            bcr_pkg::CSR_SOURCE_HEIGHT: src_h_ff <= csr_wdata[8:0];
            bcr_pkg::CSR_TARGET_WIDTH:  dst_w_ff <= csr_wdata;
            bcr_pkg::CSR_TARGET_HEIGHT: dst_h_ff <= csr_wdata;
            bcr_pkg::CSR_ANTIALIAS:     aa_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      w0_ff   <= $signed(wx_ff[aj]) * $signed(wy_ff[ai]);
      w1_ff   <= w0_ff;
      prod_ff <= $signed({1'b0, mem_rdata}) * w0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         p1_ff         <= 1'b0;
         p2_ff         <= 1'b0;
         acc_cnt_ff    <= '0;
         ax_sel_ff     <= 1'b0;
      end else begin
         p1_ff <= mem_re;
         p2_ff <= p1_ff;
         if (rsp_tvalid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer && (req_tuser == 1'(bcr_pkg::OP_COMPUTE))) begin
                  cx_ff     <= req_x;
                  cy_ff     <= req_y;
                  ax_sel_ff <= 1'b0;
                  state_ff  <= S_AXS;
               end
            end
            S_AXS: begin
               state_ff <= S_AXW;
            end
            S_AXW: begin
               if (ax_done) begin
                  if (!ax_sel_ff) begin
                     for (int k = 0; k < 4; k++) begin
                        xi_ff[k] <= ax_idx[k][XI_W-1:0];
                     end
                     wx_ff     <= ax_w;
                     ax_sel_ff <= 1'b1;
                     state_ff  <= S_AXS;
                  end else begin
                     for (int k = 0; k < 4; k++) begin
                        yi_ff[k] <= ax_idx[k][YI_W-1:0];
                     end
                     wy_ff      <= ax_w;
                     acc_cnt_ff <= '0;
                     sum_ff     <= '0;
                     wsum_ff    <= '0;
                     state_ff   <= S_ACC;
                  end
               end
            end
            S_ACC: begin
               if (mem_re) begin
                  acc_cnt_ff <= acc_cnt_ff + 5'd1;
               end
               if (p2_ff) begin
                  sum_ff  <= sum_ff + 42'(prod_ff);
                  wsum_ff <= wsum_ff + 34'(w1_ff);
               end
               if (acc_cnt_ff[4] && !p1_ff && !p2_ff) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (fin_zero) begin
                  q_ff     <= 8'd0;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  q_ff     <= (div_quo > FNW'(255)) ? 8'd255 : div_quo[7:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  pix_out_ff    <= q_ff;
                  out_x_ff      <= cx_ff;
                  out_y_ff      <= cy_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0, out_y_ff, out_x_ff, pix_out_ff};

   `BCR_ASSERT_NEXT(a_busy_after_compute, clock, reset, req_xfer && req_tuser, !req_tready)
   `BCR_ASSERT_NOW(a_acc_count, clock, reset, state_ff == S_ACC, acc_cnt_ff <= 5'd16)
   `BCR_ASSERT_NEXT(a_pipe_order, clock, reset, p1_ff, p2_ff)
   `BCR_ASSERT_NOW(a_rsp_from_out, clock, reset, $rose(rsp_tvalid_ff), $past(state_ff) == S_OUT)

endmodule
`default_nettype wire
